/* rtl/utf8d_pkg.sv */
// Shared types and helpers for the UTF-8 stream decoder.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package utf8d_pkg;

   localparam int ByteWidth  = 8;
   localparam int CodeWidth  = 32;
   localparam int CountWidth = 4;
   localparam int ExtraWidth = 3;
   localparam int SixWidth   = 6;

   typedef struct packed {
      logic [ByteWidth-1:0] byte_in;
      logic                 buffer_end;
   } req_type;

   typedef struct packed {
      logic [CodeWidth-1:0]  code_point;
      logic [CountWidth-1:0] bytes_used;
   } rsp_type;

   // continuation bytes asked for by a lead byte with both top bits set
   function automatic logic [ExtraWidth-1:0] extra_for_lead(input logic [ByteWidth-1:0] b);
      logic [ExtraWidth-1:0] n;
      unique case (b) inside
         8'b110?????: n = 3'd1;
         8'b1110????: n = 3'd2;
         8'b11110???: n = 3'd3;
         8'b111110??: n = 3'd4;
         8'b1111110?: n = 3'd5;
         8'b11111110: n = 3'd6;
         8'b11111111: n = 3'd7;
         default:     n = 3'd0;
      endcase
      return n;
   endfunction

   // lead payload (lead AND (0x3F >> k)) placed above k continuation fields
   function automatic logic [CodeWidth-1:0] lead_field(input logic [ByteWidth-1:0] lead,
                                                      input logic [ExtraWidth-1:0] k);
      logic [ByteWidth-1:0] masked;
      logic [5:0]           shift;
      logic [CodeWidth-1:0] wide;
      masked = lead & (8'h3F >> k);
      shift  = 6'({3'b000, k} * 6'd6);
      wide   = CodeWidth'(masked);
      return wide << shift;
   endfunction

endpackage

`default_nettype wire

/* rtl/utf8d_if.sv */
// Valid/ready channel interfaces for the decoder's byte and result words.
// Depends on utf8d_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface utf8d_req_if;
   import utf8d_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface utf8d_rsp_if;
   import utf8d_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/utf8d_step.sv */
// Per-byte decode step: character state registers and the result logic.
// Depends on utf8d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module utf8d_step (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire utf8d_pkg::req_type word,
   output logic                   result_valid,
   output utf8d_pkg::rsp_type     result
);
   import utf8d_pkg::*;

   logic                  in_char_ff, in_char_in;
   logic [ByteWidth-1:0]  lead_ff, lead_in;
   logic [ExtraWidth-1:0] needed_ff, needed_in;
   logic [ExtraWidth-1:0] taken_ff, taken_in;
   logic [CodeWidth-1:0]  acc_ff, acc_in;

   logic [CodeWidth-1:0]  acc_next;
   logic [ExtraWidth-1:0] taken_next;
   logic                  is_lead;
   logic                  close;

   always_comb begin
      acc_next   = {acc_ff[CodeWidth-SixWidth-1:0], word.byte_in[SixWidth-1:0]};
      taken_next = taken_ff + 3'd1;
      is_lead    = (word.byte_in[7:6] == 2'b11) && !word.buffer_end;
      close      = (taken_next == needed_ff) || word.buffer_end;

      in_char_in   = in_char_ff;
      lead_in      = lead_ff;
      needed_in    = needed_ff;
      taken_in     = taken_ff;
      acc_in       = acc_ff;
      result_valid = 1'b0;
      result       = '0;

      if (!in_char_ff) begin
         if (is_lead) begin
            in_char_in = 1'b1;
            lead_in    = word.byte_in;
            needed_in  = extra_for_lead(word.byte_in);
            taken_in   = '0;
            acc_in     = '0;
         end else begin
            result_valid      = 1'b1;
            result.bytes_used = 4'd1;
            if (!word.byte_in[7]) begin
               result.code_point = CodeWidth'(word.byte_in);
            end else begin
               result.code_point = CodeWidth'(word.byte_in[SixWidth-1:0]);
            end
         end
      end else begin
         acc_in   = acc_next;
         taken_in = taken_next;
         if (close) begin
            result_valid      = 1'b1;
            result.code_point = acc_next | lead_field(lead_ff, taken_next);
            result.bytes_used = {1'b0, taken_next} + 4'd1;
            in_char_in        = 1'b0;
            lead_in           = '0;
            needed_in         = '0;
            taken_in          = '0;
            acc_in            = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_char_ff <= 1'b0;
         needed_ff  <= '0;
         taken_ff   <= '0;
      end else if (accept) begin
         in_char_ff <= in_char_in;
         needed_ff  <= needed_in;
         taken_ff   <= taken_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         lead_ff <= lead_in;
         acc_ff  <= acc_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/utf8d_skid.sv */
// Result register with one skid entry; ready toward the decode step is registered.
// Depends on utf8d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module utf8d_skid (
   input  wire logic               clock,
   input  wire logic               reset,
   output logic                    push_ready,
   input  wire logic               push,
   input  wire utf8d_pkg::rsp_type push_word,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output utf8d_pkg::rsp_type      out_word
);
   import utf8d_pkg::*;

   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_word_ff, out_word_in;
   rsp_type skid_word_ff, skid_word_in;

   assign push_ready = !skid_valid_ff;
   assign out_valid  = out_valid_ff;
   assign out_word   = out_word_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_word_in   = out_word_ff;
      skid_word_in  = skid_word_ff;
      if (!out_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_word_in   = skid_word_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_word_in  = push_word;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_word_in  = push_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_word_ff  <= out_word_in;
      skid_word_ff <= skid_word_in;
   end

endmodule

`default_nettype wire

/* rtl/utf8_stream_decoder.sv */
// UTF-8 stream decoder top level.
//
// req (sink): one text byte per word, with buffer_end marking the last
//   byte available. A word is taken when req.valid and req.ready are high.
// rsp (source): one word per character, code_point (low 32 bits) and
//   bytes_used (1..8). A word leaves when rsp.valid and rsp.ready are high.
// Result path: a character's result is registered in the result register,
//   or in the skid entry while rsp is stalled, when the byte that completes
//   it is taken; lead bytes and inner continuation bytes give no word.
// Throughput: one byte per cycle while req.ready is high, set by the single
//   decode step between the character state and result registers.
// Stall: a result register plus one skid entry hold output words; req.ready
//   drops only while the skid entry is full, and recovers the cycle after
//   rsp.ready returns.
// Reset: synchronous; clears any open character and discards pending words.
// Depends on utf8d_pkg, utf8d_if, utf8d_step and utf8d_skid.
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_decoder (
   input  wire logic  clock,
   input  wire logic  reset,
   utf8d_req_if.sink   req,
   utf8d_rsp_if.source rsp
);
   import utf8d_pkg::*;

   logic    accept;
   logic    step_valid;
   logic    skid_ready;
   rsp_type step_word;

   assign req.ready = skid_ready;
   assign accept    = req.valid && skid_ready;

   utf8d_step u_step (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .word         (req.data),
      .result_valid (step_valid),
      .result       (step_word)
   );

   utf8d_skid u_skid (
      .clock      (clock),
      .reset      (reset),
      .push_ready (skid_ready),
      .push       (accept && step_valid),
      .push_word  (step_word),
      .out_valid  (rsp.valid),
      .out_ready  (rsp.ready),
      .out_word   (rsp.data)
   );

endmodule

`default_nettype wire

/* rtl/utf8d_checker.sv */
// Port-level checks for the UTF-8 stream decoder, bound to its top level.
// Depends on utf8d_pkg and utf8_stream_decoder.
`timescale 1ns / 1ps
`default_nettype none

module utf8d_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire utf8d_pkg::rsp_type rsp_data
);
   import utf8d_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp word changed while stalled");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.bytes_used != 4'd0) && (rsp_data.bytes_used <= 4'd8))
      else $error("bytes_used out of range");

   a_single_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.bytes_used == 4'd1) |-> rsp_data.code_point < 32'h80)
      else $error("single byte word too large");

   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind utf8_stream_decoder utf8d_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_data  (rsp.data)
);

`default_nettype wire

/* tb/sv/utf8d_char_check.sv */
// Checker for the UTF-8 stream decoder: watches the byte and result channels,
// predicts each character word and compares it with what the decoder sends.
// Depends on utf8d_pkg and utf8d_if.
`timescale 1ns / 1ps

module utf8d_char_check (
   input  wire logic clock,
   input  wire logic reset,
   utf8d_req_if      req,
   utf8d_rsp_if      rsp,
   output int        failures,
   output int        pending
);
   import utf8d_pkg::*;

   rsp_type                expected_chars [$];
   logic                   open_char;
   logic [ByteWidth-1:0]   lead_q;
   logic [ExtraWidth-1:0]  need_q;
   logic [ExtraWidth-1:0]  taken_q;
   logic [CodeWidth-1:0]   acc_q;

   initial begin
      failures = 0;
      pending  = 0;
   end

   function automatic logic [ExtraWidth-1:0] extra_count(input logic [ByteWidth-1:0] b);
      int n;
      n = 0;
      while (n < 8 && b[7-n]) n++;
      return ExtraWidth'(n - 1);
   endfunction

   task automatic report_mismatch(input string what, input logic [CodeWidth-1:0] want,
                                  input logic [CodeWidth-1:0] got);
      $display("%0t utf8d check: %s, expected %h, got %h", $time, what, want, got);
      failures++;
   endtask

   task automatic predict_char(input req_type w);
      rsp_type               ch;
      logic [63:0]           lead_bits;
      logic [ByteWidth-1:0]  lead_mask;
      int                    k;
      if (!open_char) begin
         if (!w.byte_in[7]) begin
            ch.code_point = CodeWidth'(w.byte_in);
            ch.bytes_used = CountWidth'(1);
            expected_chars.push_back(ch);
         end else if (!w.byte_in[6] || w.buffer_end) begin
            ch.code_point = CodeWidth'(w.byte_in[5:0]);
            ch.bytes_used = CountWidth'(1);
            expected_chars.push_back(ch);
         end else begin
            open_char = 1'b1;
            lead_q    = w.byte_in;
            need_q    = extra_count(w.byte_in);
            taken_q   = '0;
            acc_q     = '0;
         end
      end else begin
         acc_q   = {acc_q[CodeWidth-7:0], w.byte_in[5:0]};
         taken_q = taken_q + 1'b1;
         if (taken_q == need_q || w.buffer_end) begin
            k             = int'(taken_q);
            lead_mask     = 8'h3F >> k;
            lead_bits     = 64'(lead_q & lead_mask) << (6 * k);
            ch.code_point = acc_q | lead_bits[CodeWidth-1:0];
            ch.bytes_used = CountWidth'(k + 1);
            expected_chars.push_back(ch);
            open_char = 1'b0;
            lead_q    = '0;
            need_q    = '0;
            taken_q   = '0;
            acc_q     = '0;
         end
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         expected_chars.delete();
         open_char = 1'b0;
         lead_q    = '0;
         need_q    = '0;
         taken_q   = '0;
         acc_q     = '0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_chars.size() == 0) begin
               report_mismatch("character word with none pending", '0, rsp.data.code_point);
            end else begin
               want = expected_chars.pop_front();
               if (rsp.data.code_point !== want.code_point)
                  report_mismatch("code_point", want.code_point, rsp.data.code_point);
               if (rsp.data.bytes_used !== want.bytes_used)
                  report_mismatch("bytes_used", CodeWidth'(want.bytes_used),
                                  CodeWidth'(rsp.data.bytes_used));
            end
         end
         if (req.valid && req.ready) predict_char(req.data);
      end
      pending = expected_chars.size();
   end

endmodule

/* tb/sv/tb_utf8_stream_decoder.sv */
// Top of the UTF-8 stream decoder testbench: clock, reset, byte stimulus and
// result back-pressure, with utf8d_char_check doing the prediction and compare.
// Depends on utf8d_pkg, utf8d_if, utf8_stream_decoder and utf8d_char_check.
`timescale 1ns / 1ps

module tb_utf8_stream_decoder;
   import utf8d_pkg::*;

   localparam int CycleLimit  = 1_000_000;
   localparam int StreamBytes = 1800;

   logic clock;
   logic reset;
   int   cycles;
   int   bytes_sent;
   int   fail_count;
   int   chars_pending;
   bit   no_idle;

   utf8d_req_if req_ch ();
   utf8d_rsp_if rsp_ch ();

   utf8_stream_decoder dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   utf8d_char_check char_check (
      .clock    (clock),
      .reset    (reset),
      .req      (req_ch),
      .rsp      (rsp_ch),
      .failures (fail_count),
      .pending  (chars_pending)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   initial cycles = 0;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CycleLimit) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic int pick_extra();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 1;
      if (r < 70) return 2;
      if (r < 85) return 3;
      return $urandom_range(4, 7);
   endfunction

   task automatic send_byte(input logic [ByteWidth-1:0] b, input logic last);
      int gap;
      gap = no_idle ? 0 : pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= {b, last};
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      bytes_sent++;
   endtask

   // lead byte with a random payload, then continuations, sometimes cut short
   task automatic send_sequence();
      int                   n;
      int                   stop;
      bit                   end_flag;
      logic [ByteWidth-1:0] lead;
      logic [ByteWidth-1:0] cont;
      n        = pick_extra();
      lead     = ByteWidth'((32'hFF << (7 - n)) | ($urandom & (32'hFF >> (n + 2))));
      stop     = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : n;
      end_flag = ($urandom_range(0, 19) == 0);
      send_byte(lead, stop == 0);
      for (int i = 1; i <= stop; i++) begin
         if ($urandom_range(0, 9) == 0) cont = ByteWidth'($urandom);
         else cont = ByteWidth'(8'h80 | ($urandom & 8'h3F));
         send_byte(cont, i == stop && (stop < n || end_flag));
      end
   endtask

   initial begin
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         int stall;
         if ($urandom_range(0, 9) == 0) begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(50, 200)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            repeat (pick_gap() + 1) @(posedge clock);
            stall = pick_gap();
            if (stall > 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
      end
   end

   initial begin
      bit [8:0] opening [$];
      int       next_mode;
      int       r;
      opening = '{
         {8'h00, 1'b0}, {8'h7F, 1'b1}, {8'h80, 1'b0}, {8'hBF, 1'b1}, {8'hC3, 1'b1},
         {8'hC3, 1'b0}, {8'hA9, 1'b0},
         {8'hE2, 1'b0}, {8'h82, 1'b0}, {8'hAC, 1'b0},
         {8'hF0, 1'b0}, {8'h9F, 1'b0}, {8'h98, 1'b0}, {8'h80, 1'b0},
         {8'hE2, 1'b0}, {8'h82, 1'b1},
         {8'hFF, 1'b0}, {8'hBF, 1'b0}, {8'h80, 1'b0}, {8'hFF, 1'b0}, {8'h3F, 1'b0},
         {8'hC0, 1'b0}, {8'hAA, 1'b0}, {8'h95, 1'b0},
         {8'hC3, 1'b0}, {8'h41, 1'b0}
      };
      bytes_sent   = 0;
      no_idle      = 1'b0;
      next_mode    = 100;
      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.data  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (opening[i]) send_byte(opening[i][8:1], opening[i][0]);

      while (bytes_sent < StreamBytes) begin
         if (bytes_sent >= next_mode) begin
            no_idle   = ($urandom_range(0, 3) == 0);
            next_mode = next_mode + 100;
         end
         r = $urandom_range(0, 99);
         if (r < 30) send_byte(ByteWidth'($urandom_range(0, 127)), $urandom_range(0, 19) == 0);
         else if (r < 80) send_sequence();
         else send_byte(ByteWidth'($urandom), $urandom_range(0, 3) == 0);
      end
      req_ch.valid <= 1'b0;

      // drain outstanding characters
      repeat (2) @(posedge clock);
      while (chars_pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
